// ===== design/saclp_pkg.sv =====
// shared types, constants and codes for the cache tag controller
`timescale 1ns / 1ps
package saclp_pkg;

  localparam int LOG_MAX_SETS_DEF   = 10;
  localparam int LOG_MAX_WAYS_DEF   = 3;
  localparam int STREAM_ENTRIES_DEF = 32;
  localparam int STREAM_DEPTH_DEF   = 4;
  localparam int MAX_PREFETCH_DEF   = 3;

  localparam int ADDR_W     = 32;
  localparam int AGE_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAY_BITS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_THROUGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOCATE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFETCH_MODE  = 3'd5;

  localparam logic [2:0] PF_MODE_STREAM = 3'd4;

  typedef enum logic [2:0] {
    REQ_DEMAND    = 3'd0,
    REQ_WRITEBACK = 3'd1,
    REQ_WTHRU     = 3'd2,
    REQ_FORWARD   = 3'd3,
    REQ_PREFETCH  = 3'd4
  } req_kind_t;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] address;
    logic [3:0]        access_bytes;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic              has_request;
    logic [2:0]        request_kind;
    logic [ADDR_W-1:0] request_address;
    logic [3:0]        request_bytes;
    logic              last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_DEM,
    S_LK_DEM,
    S_SCHK,
    S_FILL,
    S_EM_DEM,
    S_PF_NEXT,
    S_RD_PF,
    S_LK_PF,
    S_EM_PF,
    S_RD_TOUCH,
    S_TOUCH,
    S_EM_WT,
    S_EM_FWD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic      accept;
    logic      clr;
    logic      rd;
    logic      sel_pf;
    logic      lookup;
    logic      sop;
    logic      fill;
    logic      fill_touch;
    logic      touch;
    logic      pf_next;
    logic      emit;
    req_kind_t emit_kind;
    logic      flush;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       hit;
    logic       wb_need;
    logic       can_emit;
    logic       out_free;
    logic       stream_hit;
    logic       is_read;
    logic       walloc;
    logic       wthru;
    logic [1:0] npf;
  } sts_t;

endpackage

// ===== design/saclp_ctrl.sv =====
// access sequencer state machine
`timescale 1ns / 1ps
module saclp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  saclp_pkg::sts_t sts,
  output saclp_pkg::cmd_t cmd
);

  saclp_pkg::state_t state_r, state_nxt;
  logic [1:0] pf_cnt_r, pf_cnt_nxt;
  logic       pf_phase_r, pf_phase_nxt;
  logic       via_r, via_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= saclp_pkg::S_CLEAR;
      pf_cnt_r   <= '0;
      pf_phase_r <= 1'b0;
      via_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pf_cnt_r   <= pf_cnt_nxt;
      pf_phase_r <= pf_phase_nxt;
      via_r      <= via_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pf_cnt_nxt    = pf_cnt_r;
    pf_phase_nxt  = pf_phase_r;
    via_nxt       = via_r;
    cmd           = '0;
    cmd.emit_kind = saclp_pkg::REQ_DEMAND;
    in_ready      = 1'b0;
    case (state_r)
      saclp_pkg::S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_nxt = saclp_pkg::S_IDLE;
      end
      saclp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = saclp_pkg::S_RD_DEM;
        end
      end
      saclp_pkg::S_RD_DEM: begin
        cmd.rd    = 1'b1;
        state_nxt = saclp_pkg::S_LK_DEM;
      end
      saclp_pkg::S_LK_DEM: begin
        cmd.lookup   = 1'b1;
        pf_phase_nxt = 1'b0;
        if (!sts.is_read && !sts.hit && !sts.walloc) state_nxt = saclp_pkg::S_EM_FWD;
        else if (sts.hit) state_nxt = saclp_pkg::S_RD_TOUCH;
        else state_nxt = saclp_pkg::S_SCHK;
      end
      saclp_pkg::S_SCHK: begin
        cmd.sop   = 1'b1;
        via_nxt   = sts.stream_hit;
        state_nxt = saclp_pkg::S_FILL;
      end
      saclp_pkg::S_FILL: begin
        cmd.sel_pf = pf_phase_r;
        if (!sts.wb_need || sts.can_emit) begin
          cmd.fill       = 1'b1;
          cmd.fill_touch = pf_phase_r;
          if (sts.wb_need) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = saclp_pkg::REQ_WRITEBACK;
          end
          if (pf_phase_r) state_nxt = saclp_pkg::S_EM_PF;
          else if (via_r) state_nxt = saclp_pkg::S_RD_TOUCH;
          else state_nxt = saclp_pkg::S_EM_DEM;
        end
      end
      saclp_pkg::S_EM_DEM: begin
        if (sts.can_emit) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = saclp_pkg::REQ_DEMAND;
          pf_cnt_nxt    = sts.npf;
          state_nxt     = saclp_pkg::S_PF_NEXT;
        end
      end
      saclp_pkg::S_PF_NEXT: begin
        if (pf_cnt_r != 2'd0) begin
          cmd.pf_next = 1'b1;
          pf_cnt_nxt  = pf_cnt_r - 2'd1;
          state_nxt   = saclp_pkg::S_RD_PF;
        end else begin
          state_nxt = saclp_pkg::S_RD_TOUCH;
        end
      end
      saclp_pkg::S_RD_PF: begin
        cmd.rd     = 1'b1;
        cmd.sel_pf = 1'b1;
        state_nxt  = saclp_pkg::S_LK_PF;
      end
      saclp_pkg::S_LK_PF: begin
        cmd.sel_pf = 1'b1;
        if (sts.hit) begin
          state_nxt = saclp_pkg::S_PF_NEXT;
        end else begin
          pf_phase_nxt = 1'b1;
          state_nxt    = saclp_pkg::S_FILL;
        end
      end
      saclp_pkg::S_EM_PF: begin
        if (sts.can_emit) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = saclp_pkg::REQ_PREFETCH;
          state_nxt     = saclp_pkg::S_PF_NEXT;
        end
      end
      saclp_pkg::S_RD_TOUCH: begin
        cmd.rd    = 1'b1;
        state_nxt = saclp_pkg::S_TOUCH;
      end
      saclp_pkg::S_TOUCH: begin
        cmd.touch = 1'b1;
        if (!sts.is_read && sts.wthru) state_nxt = saclp_pkg::S_EM_WT;
        else state_nxt = saclp_pkg::S_DONE;
      end
      saclp_pkg::S_EM_WT: begin
        if (sts.can_emit) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = saclp_pkg::REQ_WTHRU;
          state_nxt     = saclp_pkg::S_DONE;
        end
      end
      saclp_pkg::S_EM_FWD: begin
        if (sts.can_emit) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = saclp_pkg::REQ_FORWARD;
          state_nxt     = saclp_pkg::S_DONE;
        end
      end
      saclp_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = saclp_pkg::S_IDLE;
        end
      end
      default: state_nxt = saclp_pkg::S_CLEAR;
    endcase
  end

endmodule

// ===== design/saclp_dp.sv =====
// tag/age memory, stream buffer, config registers and result queue
`timescale 1ns / 1ps
module saclp_dp #(
  parameter int LOG_MAX_SETS   = saclp_pkg::LOG_MAX_SETS_DEF,
  parameter int LOG_MAX_WAYS   = saclp_pkg::LOG_MAX_WAYS_DEF,
  parameter int STREAM_ENTRIES = saclp_pkg::STREAM_ENTRIES_DEF,
  parameter int STREAM_DEPTH   = saclp_pkg::STREAM_DEPTH_DEF,
  parameter int MAX_PREFETCH   = saclp_pkg::MAX_PREFETCH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  saclp_pkg::in_item_t                 in_data,
  input  logic                                cfg_we,
  input  logic [saclp_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [saclp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output saclp_pkg::out_item_t                out_data,
  input  saclp_pkg::cmd_t                     cmd,
  output saclp_pkg::sts_t                     sts
);

  localparam int NW    = 1 << LOG_MAX_WAYS;
  localparam int WIW   = (LOG_MAX_WAYS > 0) ? LOG_MAX_WAYS : 1;
  localparam int ROWS  = 1 << LOG_MAX_SETS;
  localparam int SIW   = (LOG_MAX_SETS > 0) ? LOG_MAX_SETS : 1;
  localparam int CLRW  = LOG_MAX_SETS + 1;
  localparam int SE    = STREAM_ENTRIES;
  localparam int SEW   = $clog2(STREAM_ENTRIES);
  localparam int AW    = saclp_pkg::ADDR_W;
  localparam int GW    = saclp_pkg::AGE_W;

  // config registers
  logic [3:0] off_r, setb_r;
  logic [1:0] wayb_r;
  logic       wt_r, wa_r;
  logic [2:0] pfm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= 4'd6;
      wayb_r <= 2'd2;
      setb_r <= 4'd6;
      wt_r   <= 1'b0;
      wa_r   <= 1'b1;
      pfm_r  <= 3'd0;
    end else if (cfg_we) begin
      case (cfg_idx)
        saclp_pkg::CFG_OFFSET_BITS:    off_r  <= cfg_wdata;
        saclp_pkg::CFG_WAY_BITS:       wayb_r <= cfg_wdata[1:0];
        saclp_pkg::CFG_SET_BITS:       setb_r <= cfg_wdata;
        saclp_pkg::CFG_WRITE_THROUGH:  wt_r   <= cfg_wdata[0];
        saclp_pkg::CFG_WRITE_ALLOCATE: wa_r   <= cfg_wdata[0];
        saclp_pkg::CFG_PREFETCH_MODE:  pfm_r  <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // access registers
  saclp_pkg::in_item_t in_r;
  logic [AW-1:0]       pf_addr_r;
  logic                hit_r;
  logic [AW-1:0]       bsize;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_r      <= in_data;
      pf_addr_r <= in_data.address;
    end else if (cmd.pf_next) begin
      pf_addr_r <= pf_addr_r + bsize;
    end
    if (cmd.lookup) hit_r <= sts.hit;
  end

  // address split
  logic [AW-1:0]  addr_sel, tag, set32, baddr;
  logic [3:0]     gs;
  logic [2:0]     we3;
  logic [4:0]     sh;
  logic [SIW-1:0] set_idx;
  logic [1:0]     npf;

  always_comb begin
    addr_sel = cmd.sel_pf ? pf_addr_r : in_r.address;
    gs       = (setb_r > 4'(LOG_MAX_SETS)) ? 4'(LOG_MAX_SETS) : setb_r;
    we3      = ({1'b0, wayb_r} > 3'(LOG_MAX_WAYS)) ? 3'(LOG_MAX_WAYS) : {1'b0, wayb_r};
    sh       = 5'(off_r) + 5'(gs);
    tag      = addr_sel >> sh;
    set32    = (addr_sel >> off_r) & ((32'd1 << gs) - 32'd1);
    set_idx  = set32[SIW-1:0];
    bsize    = 32'd1 << off_r;
    baddr    = in_r.address & ~(bsize - 32'd1);
    npf      = 2'd0;
    if (pfm_r >= 3'd1 && pfm_r <= 3'd3) begin
      npf = (pfm_r < 3'(MAX_PREFETCH)) ? pfm_r[1:0] : 2'(MAX_PREFETCH);
    end
  end

  // set memory, one row per set
  logic [NW-1:0][AW-1:0] tag_mem [ROWS];
  logic [NW-1:0][GW-1:0] age_mem [ROWS];
  logic [NW-1:0]         val_mem [ROWS];
  logic [NW-1:0]         dty_mem [ROWS];

  logic [NW-1:0][AW-1:0] row_tag_q, w_tag, f_tag;
  logic [NW-1:0][GW-1:0] row_age_q, w_age, t_age;
  logic [NW-1:0]         row_val_q, row_dty_q, w_val, w_dty, f_val, f_dty, t_val, active;
  logic                  mem_we;
  logic [SIW-1:0]        mem_wa;
  logic [CLRW-1:0]       clr_cnt_r;
  logic                  clr_done;

  assign clr_done = (clr_cnt_r == CLRW'(ROWS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr && !clr_done) begin
      clr_cnt_r <= clr_cnt_r + CLRW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      row_tag_q <= tag_mem[set_idx];
      row_age_q <= age_mem[set_idx];
      row_val_q <= val_mem[set_idx];
      row_dty_q <= dty_mem[set_idx];
    end
    if (mem_we) begin
      tag_mem[mem_wa] <= w_tag;
      age_mem[mem_wa] <= w_age;
      val_mem[mem_wa] <= w_val;
      dty_mem[mem_wa] <= w_dty;
    end
  end

  // way lookup, victim choice and row update
  logic           hit, inv_found, wb_need;
  logic [WIW-1:0] hw, inv_w, vmax, vic, t_idx;
  logic [AW-1:0]  wb_addr;

  always_comb begin
    hit       = 1'b0;
    hw        = '0;
    inv_found = 1'b0;
    inv_w     = '0;
    vmax      = '0;
    for (int w = NW - 1; w >= 0; w--) begin
      active[w] = ((w >> we3) == 0);
      if (active[w] && row_val_q[w] && row_tag_q[w] == tag) begin
        hit = 1'b1;
        hw  = WIW'(w);
      end
      if (active[w] && !row_val_q[w]) begin
        inv_found = 1'b1;
        inv_w     = WIW'(w);
      end
    end
    for (int w = 0; w < NW; w++) begin
      if (active[w] && row_age_q[w] > row_age_q[vmax]) vmax = WIW'(w);
    end
    vic     = inv_found ? inv_w : vmax;
    wb_need = !inv_found && row_dty_q[vic] && !wt_r;
    wb_addr = (row_tag_q[vic] << sh) + (set32 << off_r);

    f_tag      = row_tag_q;
    f_val      = row_val_q;
    f_dty      = row_dty_q;
    f_tag[vic] = tag;
    f_val[vic] = 1'b1;
    f_dty[vic] = 1'b0;

    t_idx = cmd.fill ? vic : hw;
    t_val = cmd.fill ? f_val : row_val_q;
    t_age = row_age_q;
    for (int w = 0; w < NW; w++) begin
      if (active[w]) begin
        if (WIW'(w) == t_idx) t_age[w] = '0;
        else if (t_val[w] && row_age_q[w] != {GW{1'b1}}) t_age[w] = row_age_q[w] + GW'(1);
      end
    end

    mem_we = 1'b0;
    mem_wa = set_idx;
    w_tag  = row_tag_q;
    w_val  = row_val_q;
    w_dty  = row_dty_q;
    w_age  = t_age;
    if (cmd.clr) begin
      mem_we = !clr_done;
      mem_wa = clr_cnt_r[SIW-1:0];
      w_tag  = '0;
      w_val  = '0;
      w_dty  = '0;
      w_age  = '0;
    end else if (cmd.fill) begin
      mem_we = 1'b1;
      w_tag  = f_tag;
      w_val  = f_val;
      w_dty  = f_dty;
      w_age  = cmd.fill_touch ? t_age : row_age_q;
    end else if (cmd.touch) begin
      mem_we = hit;
      if (!in_r.mode && !wt_r) w_dty[hw] = 1'b1;
    end
  end

  // stream buffer
  logic [SE-1:0]        sv_r, smatch_r;
  logic [AW-1:0]        sa_r [SE];
  logic [2:0]           sr_r [SE];
  logic [SEW-1:0]       sp_r, sp_inc, fm, fi, ai;
  logic                 fm_found, fi_found, shit, smode;

  assign smode = (pfm_r == saclp_pkg::PF_MODE_STREAM);

  always_comb begin
    fm_found = 1'b0;
    fm       = '0;
    fi_found = 1'b0;
    fi       = '0;
    for (int i = SE - 1; i >= 0; i--) begin
      if (smatch_r[i]) begin
        fm_found = 1'b1;
        fm       = SEW'(i);
      end
      if (!sv_r[i]) begin
        fi_found = 1'b1;
        fi       = SEW'(i);
      end
    end
    shit   = fm_found && (sr_r[fm] != 3'd0);
    sp_inc = (({1'b0, sp_r} + (SEW+1)'(1)) >= (SEW+1)'(SE)) ? '0 : sp_r + SEW'(1);
    ai     = fi_found ? fi : sp_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
      sp_r <= '0;
    end else if (cmd.sop && smode) begin
      if (shit) begin
        if (sr_r[fm] == 3'd1) sv_r[fm] <= 1'b0;
      end else begin
        if (!fi_found) sp_r <= sp_inc;
        sv_r[ai] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      for (int i = 0; i < SE; i++) smatch_r[i] <= sv_r[i] && (sa_r[i] == baddr);
    end
    if (cmd.sop && smode) begin
      if (shit) begin
        sr_r[fm] <= sr_r[fm] - 3'd1;
        sa_r[fm] <= baddr + bsize;
      end else begin
        sr_r[ai] <= 3'(STREAM_DEPTH);
        sa_r[ai] <= baddr + bsize;
      end
    end
  end

  // result queue: one pending item ahead of the output register
  logic          pend_v_r, out_v_r, can_emit, out_free;
  logic [2:0]    pend_kind_r;
  logic [AW-1:0] pend_addr_r, e_addr;
  logic [3:0]    pend_bytes_r, e_bytes;
  saclp_pkg::out_item_t out_r;

  assign can_emit = !pend_v_r || !out_v_r || out_ready;
  assign out_free = !out_v_r || out_ready;

  always_comb begin
    case (cmd.emit_kind)
      saclp_pkg::REQ_WRITEBACK: begin
        e_addr  = wb_addr;
        e_bytes = 4'd1;
      end
      saclp_pkg::REQ_PREFETCH: begin
        e_addr  = pf_addr_r;
        e_bytes = 4'd1;
      end
      default: begin
        e_addr  = in_r.address;
        e_bytes = in_r.access_bytes;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else if (cmd.emit) begin
      pend_v_r <= 1'b1;
      if (pend_v_r) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end else if (cmd.flush) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pend_kind_r  <= cmd.emit_kind;
      pend_addr_r  <= e_addr;
      pend_bytes_r <= e_bytes;
      if (pend_v_r) out_r <= {hit_r, 1'b1, pend_kind_r, pend_addr_r, pend_bytes_r, 1'b0};
    end else if (cmd.flush) begin
      if (pend_v_r) out_r <= {hit_r, 1'b1, pend_kind_r, pend_addr_r, pend_bytes_r, 1'b1};
      else out_r <= {hit_r, 1'b0, 3'd0, 32'd0, 4'd0, 1'b1};
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    sts            = '0;
    sts.clr_done   = clr_done;
    sts.hit        = hit;
    sts.wb_need    = wb_need;
    sts.can_emit   = can_emit;
    sts.out_free   = out_free;
    sts.stream_hit = smode && shit;
    sts.is_read    = in_r.mode;
    sts.walloc     = wa_r;
    sts.wthru      = wt_r;
    sts.npf        = npf;
  end

`ifndef SYNTHESIS
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> can_emit) else $error("item emitted with queue full");
  a_flush_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> (out_free && !cmd.emit)) else $error("flush without room");
  a_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fill || cmd.touch) |-> !cmd.rd) else $error("row read and write together");
  a_stream_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sop |-> !hit_r) else $error("stream buffer used on a hit");
`endif

endmodule

// ===== design/set_assoc_cache_lru_prefetch_unit.sv =====
// top level of the set-associative cache tag controller with prefetch
// throughput: one item at a time, next is taken in the cycle after the last result is queued
// reset: synchronous; afterwards a clearing pass over every row of
// the set memory runs before the first item is taken
`timescale 1ns / 1ps
module set_assoc_cache_lru_prefetch_unit #(
  parameter int LOG_MAX_SETS   = saclp_pkg::LOG_MAX_SETS_DEF,
  parameter int LOG_MAX_WAYS   = saclp_pkg::LOG_MAX_WAYS_DEF,
  parameter int STREAM_ENTRIES = saclp_pkg::STREAM_ENTRIES_DEF,
  parameter int STREAM_DEPTH   = saclp_pkg::STREAM_DEPTH_DEF,
  parameter int MAX_PREFETCH   = saclp_pkg::MAX_PREFETCH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  saclp_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output saclp_pkg::out_item_t             out_data,
  input  logic                             cfg_we,
  input  logic [saclp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [saclp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  saclp_pkg::cmd_t cmd;
  saclp_pkg::sts_t sts;

  saclp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  saclp_dp #(
    .LOG_MAX_SETS   (LOG_MAX_SETS),
    .LOG_MAX_WAYS   (LOG_MAX_WAYS),
    .STREAM_ENTRIES (STREAM_ENTRIES),
    .STREAM_DEPTH   (STREAM_DEPTH),
    .MAX_PREFETCH   (MAX_PREFETCH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the cache tag controller with lru and prefetch
`timescale 1ns / 1ps
module testbench;

  localparam int LMS   = saclp_pkg::LOG_MAX_SETS_DEF;
  localparam int LMW   = saclp_pkg::LOG_MAX_WAYS_DEF;
  localparam int NSE   = saclp_pkg::STREAM_ENTRIES_DEF;
  localparam int LINES = 1 << (LMS + LMW);

  typedef struct {
    bit                   valid;
    logic                 hit;
    logic                 has_request;
    saclp_pkg::req_kind_t kind;
  } first_chk_t;

  typedef struct {
    bit                              is_cfg;
    logic [saclp_pkg::CFG_IDX_W-1:0] idx;
    logic [3:0]                      val;
    saclp_pkg::in_item_t             item;
    first_chk_t                      chk;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  saclp_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  saclp_pkg::out_item_t out_data;
  logic cfg_we;
  logic [saclp_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [saclp_pkg::CFG_DATA_W-1:0] cfg_wdata;

  set_assoc_cache_lru_prefetch_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // cache state mirror
  logic [31:0] tag_mem [0:LINES-1];
  bit          line_vld [0:LINES-1];
  bit          line_drt [0:LINES-1];
  logic [15:0] line_age [0:LINES-1];
  bit          strm_vld [0:NSE-1];
  logic [31:0] strm_addr [0:NSE-1];
  logic [2:0]  strm_left [0:NSE-1];
  int          strm_ptr;

  logic [3:0] r_off;
  logic [1:0] r_way;
  logic [3:0] r_set;
  bit         r_wt;
  bit         r_wa;
  logic [2:0] r_pf;
  int         gb, gs, gways;

  saclp_pkg::out_item_t access_reqs[$];
  saclp_pkg::out_item_t pending_results[$];
  first_chk_t           first_checks[$];
  first_chk_t           cur_chk;
  row_t                 directed[$];
  int                   errs;
  bit                   calm;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void put_req(saclp_pkg::req_kind_t k, logic [31:0] a, logic [3:0] n);
    saclp_pkg::out_item_t r;
    r = '0;
    r.has_request = 1'b1;
    r.request_kind = k;
    r.request_address = a;
    r.request_bytes = n;
    access_reqs.insert(access_reqs.size(), r);
  endfunction

  function automatic int lidx(int set_i, int w);
    return ((set_i << LMW) | w) & (LINES - 1);
  endfunction

  function automatic int find_way(int set_i, logic [31:0] tg);
    for (int w = 0; w < gways; w++)
      if (line_vld[lidx(set_i, w)] && tag_mem[lidx(set_i, w)] == tg) return w;
    return -1;
  endfunction

  function automatic void place_block(int set_i, logic [31:0] tg);
    int victim;
    bit found;
    logic [31:0] wa;
    victim = 0;
    found = 0;
    for (int w = 0; w < gways; w++) begin
      if (!found && !line_vld[lidx(set_i, w)]) begin
        victim = w;
        found = 1;
      end
    end
    if (!found) begin
      for (int w = 0; w < gways; w++)
        if (line_age[lidx(set_i, w)] > line_age[lidx(set_i, victim)]) victim = w;
      if (line_drt[lidx(set_i, victim)] && !r_wt) begin
        wa = (tag_mem[lidx(set_i, victim)] << (gb + gs)) + (32'(set_i) << gb);
        put_req(saclp_pkg::REQ_WRITEBACK, wa, 4'd1);
      end
    end
    line_drt[lidx(set_i, victim)] = 0;
    tag_mem[lidx(set_i, victim)] = tg;
    line_vld[lidx(set_i, victim)] = 1;
  endfunction

  function automatic int refresh_age(int set_i, logic [31:0] tg);
    int hw;
    int i;
    hw = find_way(set_i, tg);
    if (hw < 0) return -1;
    for (int w = 0; w < gways; w++) begin
      i = lidx(set_i, w);
      if (w == hw) line_age[i] = '0;
      else if (line_vld[i] && line_age[i] != 16'hFFFF) line_age[i]++;
    end
    return hw;
  endfunction

  function automatic bit stream_take(logic [31:0] ba);
    for (int i = 0; i < NSE; i++) begin
      if (strm_vld[i] && strm_addr[i] == ba) begin
        if (strm_left[i] == 0) return 0;
        strm_left[i]--;
        strm_addr[i] = ba + (32'd1 << gb);
        if (strm_left[i] == 0) strm_vld[i] = 0;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic void stream_open(logic [31:0] ba);
    int i;
    i = 0;
    while (i < NSE && strm_vld[i]) i++;
    if (i == NSE) begin
      strm_ptr++;
      if (strm_ptr >= NSE) strm_ptr = 0;
      i = strm_ptr;
    end
    strm_vld[i] = 1;
    strm_addr[i] = ba + (32'd1 << gb);
    strm_left[i] = 3'(saclp_pkg::STREAM_DEPTH_DEF);
  endfunction

  function automatic void prefetch_after(logic [31:0] a, int cnt);
    logic [31:0] tg;
    int st;
    for (int i = 0; i < cnt; i++) begin
      a = a + (32'd1 << gb);
      tg = a >> (gb + gs);
      st = int'((a >> gb) & ((32'd1 << gs) - 1));
      if (find_way(st, tg) < 0) begin
        place_block(st, tg);
        put_req(saclp_pkg::REQ_PREFETCH, a, 4'd1);
        void'(refresh_age(st, tg));
      end
    end
  endfunction

  function automatic void predict_access(saclp_pkg::in_item_t it);
    logic [31:0] tg, ba;
    int st, npf, w;
    bit hit, smode;
    saclp_pkg::out_item_t r;
    access_reqs.delete();
    gb = int'(r_off);
    gs = (int'(r_set) > LMS) ? LMS : int'(r_set);
    gways = 1 << ((int'(r_way) > LMW) ? LMW : int'(r_way));
    smode = (r_pf == saclp_pkg::PF_MODE_STREAM);
    npf = 0;
    if (r_pf >= 3'd1 && r_pf <= 3'd3)
      npf = (int'(r_pf) < saclp_pkg::MAX_PREFETCH_DEF) ? int'(r_pf)
                                                       : saclp_pkg::MAX_PREFETCH_DEF;
    tg = it.address >> (gb + gs);
    st = int'((it.address >> gb) & ((32'd1 << gs) - 1));
    ba = it.address & ~((32'd1 << gb) - 1);
    hit = find_way(st, tg) >= 0;
    if (!it.mode && !hit && !r_wa) begin
      put_req(saclp_pkg::REQ_FORWARD, it.address, it.access_bytes);
    end else begin
      if (!hit) begin
        if (smode && stream_take(ba)) begin
          place_block(st, tg);
        end else begin
          if (smode) stream_open(ba);
          place_block(st, tg);
          put_req(saclp_pkg::REQ_DEMAND, it.address, it.access_bytes);
          prefetch_after(it.address, npf);
        end
      end
      w = refresh_age(st, tg);
      if (!it.mode) begin
        if (!r_wt) begin
          if (w >= 0) line_drt[lidx(st, w)] = 1;
        end else begin
          put_req(saclp_pkg::REQ_WTHRU, it.address, it.access_bytes);
        end
      end
    end
    if (access_reqs.size() == 0) begin
      r = '0;
      access_reqs.insert(0, r);
    end
    foreach (access_reqs[k]) begin
      r = access_reqs[k];
      r.hit = hit;
      r.last = (k == access_reqs.size() - 1);
      pending_results.insert(pending_results.size(), r);
    end
  endfunction

  function automatic void check_result(saclp_pkg::out_item_t got);
    saclp_pkg::out_item_t e;
    if (pending_results.size() == 0) begin
      $error("unexpected result item %h", got);
      errs++;
      return;
    end
    e = pending_results.pop_front();
    if (got.hit !== e.hit) begin
      $error("hit expected %0d got %0d", e.hit, got.hit);
      errs++;
    end
    if (got.has_request !== e.has_request) begin
      $error("has_request expected %0d got %0d", e.has_request, got.has_request);
      errs++;
    end
    if (got.request_kind !== e.request_kind) begin
      $error("request_kind expected %0d got %0d", e.request_kind, got.request_kind);
      errs++;
    end
    if (got.request_address !== e.request_address) begin
      $error("request_address expected %h got %h", e.request_address, got.request_address);
      errs++;
    end
    if (got.request_bytes !== e.request_bytes) begin
      $error("request_bytes expected %0d got %0d", e.request_bytes, got.request_bytes);
      errs++;
    end
    if (got.last !== e.last) begin
      $error("last expected %0d got %0d", e.last, got.last);
      errs++;
    end
    if (got.last && first_checks.size() != 0) void'(first_checks.pop_front());
  endfunction

  // typed first-result expectations of directed rows
  bit at_first;
  always @(posedge clk) begin
    if (!rst_n) begin
      at_first <= 1'b1;
    end else begin
      if (in_valid && in_ready) begin
        predict_access(in_data);
        first_checks.insert(first_checks.size(), cur_chk);
      end
      if (out_valid && out_ready) begin
        if (at_first && first_checks.size() != 0 && first_checks[0].valid) begin
          if (out_data.hit !== first_checks[0].hit ||
              out_data.has_request !== first_checks[0].has_request ||
              (first_checks[0].has_request && out_data.request_kind !== first_checks[0].kind))
          begin
            $error("first result expected hit %0d has_request %0d request_kind %0d got %h",
                   first_checks[0].hit, first_checks[0].has_request, first_checks[0].kind,
                   out_data);
            errs++;
          end
        end
        check_result(out_data);
        at_first <= out_data.last;
      end
    end
  end

  // result side stalls
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      n = calm ? 0 : $urandom_range(0, 8);
      @(negedge clk);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic drive_item(saclp_pkg::in_item_t it, first_chk_t c);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    cur_chk <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [saclp_pkg::CFG_IDX_W-1:0] idx, logic [3:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      saclp_pkg::CFG_OFFSET_BITS:    r_off = val;
      saclp_pkg::CFG_WAY_BITS:       r_way = val[1:0];
      saclp_pkg::CFG_SET_BITS:       r_set = val;
      saclp_pkg::CFG_WRITE_THROUGH:  r_wt = val[0];
      saclp_pkg::CFG_WRITE_ALLOCATE: r_wa = val[0];
      saclp_pkg::CFG_PREFETCH_MODE:  r_pf = val[2:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic void add_cfg(logic [saclp_pkg::CFG_IDX_W-1:0] idx, logic [3:0] val);
    row_t r;
    r.is_cfg = 1;
    r.idx = idx;
    r.val = val;
    r.item = '0;
    r.chk = '{0, 1'b0, 1'b0, saclp_pkg::REQ_DEMAND};
    directed.insert(directed.size(), r);
  endfunction

  function automatic void add_acc(int md, logic [31:0] a, logic [3:0] n, int typed,
                                  int h, int hr, saclp_pkg::req_kind_t k);
    row_t r;
    r.is_cfg = 0;
    r.idx = '0;
    r.val = '0;
    r.item.mode = 1'(md);
    r.item.address = a;
    r.item.access_bytes = n;
    r.chk = '{1'(typed), 1'(h), 1'(hr), k};
    directed.insert(directed.size(), r);
  endfunction

  initial begin
    saclp_pkg::in_item_t it;
    first_chk_t none;
    logic [31:0] a, prev;
    int sh, pick;
    bit in_cfg;
    errs = 0;
    calm = 0;
    none = '{0, 1'b0, 1'b0, saclp_pkg::REQ_DEMAND};
    cur_chk = none;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    r_off = 4'd6; r_way = 2'd2; r_set = 4'd6; r_wt = 0; r_wa = 1; r_pf = 3'd0;
    for (int i = 0; i < LINES; i++) begin
      tag_mem[i] = '0; line_vld[i] = 0; line_drt[i] = 0; line_age[i] = '0;
    end
    for (int i = 0; i < NSE; i++) begin
      strm_vld[i] = 0; strm_addr[i] = '0; strm_left[i] = 3'd1;
    end
    strm_ptr = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_acc(1, 32'h0000_0000, 4'd1, 1, 0, 1, saclp_pkg::REQ_DEMAND);
    add_acc(1, 32'h0000_0004, 4'd8, 1, 1, 0, saclp_pkg::REQ_DEMAND);
    add_acc(0, 32'hFFFF_FFFF, 4'd8, 1, 0, 1, saclp_pkg::REQ_DEMAND);
    add_acc(0, 32'hFFFF_FFC0, 4'd1, 1, 1, 0, saclp_pkg::REQ_DEMAND);
    add_acc(0, 32'h0000_1000, 4'd4, 0, 0, 0, saclp_pkg::REQ_DEMAND);
    add_acc(0, 32'h0000_2000, 4'd4, 0, 0, 0, saclp_pkg::REQ_DEMAND);
    add_acc(0, 32'h0000_3000, 4'd4, 0, 0, 0, saclp_pkg::REQ_DEMAND);
    add_acc(0, 32'h0000_4000, 4'd4, 0, 0, 0, saclp_pkg::REQ_DEMAND);
    add_acc(0, 32'h0000_5000, 4'd4, 1, 0, 1, saclp_pkg::REQ_WRITEBACK);
    add_cfg(saclp_pkg::CFG_WRITE_THROUGH, 4'd1);
    add_cfg(saclp_pkg::CFG_WRITE_ALLOCATE, 4'd0);
    add_acc(0, 32'h0009_0000, 4'd3, 1, 0, 1, saclp_pkg::REQ_FORWARD);
    add_acc(0, 32'h0000_2000, 4'd2, 1, 1, 1, saclp_pkg::REQ_WTHRU);
    add_cfg(saclp_pkg::CFG_PREFETCH_MODE, 4'd3);
    add_cfg(saclp_pkg::CFG_OFFSET_BITS, 4'd0);
    add_cfg(saclp_pkg::CFG_WAY_BITS, 4'd0);
    add_cfg(saclp_pkg::CFG_SET_BITS, 4'd15);
    add_acc(1, 32'h0000_0100, 4'd5, 1, 0, 1, saclp_pkg::REQ_DEMAND);
    add_acc(1, 32'h0000_0101, 4'd1, 0, 0, 0, saclp_pkg::REQ_DEMAND);
    add_acc(1, 32'h0000_0103, 4'd2, 0, 0, 0, saclp_pkg::REQ_DEMAND);
    add_acc(1, 32'hFFFF_FFFF, 4'd8, 0, 0, 0, saclp_pkg::REQ_DEMAND);
    add_cfg(saclp_pkg::CFG_PREFETCH_MODE, 4'd4);
    add_cfg(saclp_pkg::CFG_OFFSET_BITS, 4'd8);
    add_cfg(saclp_pkg::CFG_WAY_BITS, 4'd3);
    add_cfg(saclp_pkg::CFG_SET_BITS, 4'd0);
    add_cfg(saclp_pkg::CFG_WRITE_ALLOCATE, 4'd1);
    add_acc(1, 32'h0001_0000, 4'd2, 1, 0, 1, saclp_pkg::REQ_DEMAND);
    add_acc(1, 32'h0001_0100, 4'd2, 1, 0, 0, saclp_pkg::REQ_DEMAND);
    add_acc(0, 32'h0001_0200, 4'd7, 0, 0, 0, saclp_pkg::REQ_DEMAND);
    add_acc(1, 32'h0001_0300, 4'd1, 0, 0, 0, saclp_pkg::REQ_DEMAND);
    add_acc(1, 32'h0001_0400, 4'd1, 0, 0, 0, saclp_pkg::REQ_DEMAND);
    add_cfg(saclp_pkg::CFG_PREFETCH_MODE, 4'd7);
    add_cfg(saclp_pkg::CFG_WRITE_THROUGH, 4'd0);
    add_acc(1, 32'h0000_0077, 4'd1, 0, 0, 0, saclp_pkg::REQ_DEMAND);
    add_acc(0, 32'h1234_5678, 4'd8, 0, 0, 0, saclp_pkg::REQ_DEMAND);

    // clearing pass after reset
    repeat ((1 << LMS) + 40) @(posedge clk);
    in_cfg = 0;
    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        if (!in_cfg) wait_quiet();
        in_cfg = 1;
        write_reg(directed[i].idx, directed[i].val);
      end else begin
        if (in_cfg) begin
          @(negedge clk);
          cfg_we <= 1'b0;
        end
        in_cfg = 0;
        drive_item(directed[i].item, directed[i].chk);
      end
    end

    prev = '0;
    for (int ph = 0; ph < 8; ph++) begin
      wait_quiet();
      calm = (ph % 3 == 2);
      if (ph == 0) begin
        write_reg(saclp_pkg::CFG_OFFSET_BITS, 4'd0);
        write_reg(saclp_pkg::CFG_WAY_BITS, 4'd0);
        write_reg(saclp_pkg::CFG_SET_BITS, 4'd0);
        write_reg(saclp_pkg::CFG_WRITE_THROUGH, 4'd0);
        write_reg(saclp_pkg::CFG_WRITE_ALLOCATE, 4'd0);
        write_reg(saclp_pkg::CFG_PREFETCH_MODE, 4'd0);
      end else if (ph == 1) begin
        write_reg(saclp_pkg::CFG_OFFSET_BITS, 4'd8);
        write_reg(saclp_pkg::CFG_WAY_BITS, 4'd3);
        write_reg(saclp_pkg::CFG_SET_BITS, 4'd10);
        write_reg(saclp_pkg::CFG_WRITE_THROUGH, 4'd1);
        write_reg(saclp_pkg::CFG_WRITE_ALLOCATE, 4'd1);
        write_reg(saclp_pkg::CFG_PREFETCH_MODE, 4'd4);
      end else begin
        write_reg(saclp_pkg::CFG_OFFSET_BITS, 4'($urandom_range(0, 8)));
        write_reg(saclp_pkg::CFG_WAY_BITS, 4'($urandom_range(0, 3)));
        write_reg(saclp_pkg::CFG_SET_BITS, 4'($urandom_range(0, 15)));
        write_reg(saclp_pkg::CFG_WRITE_THROUGH, 4'($urandom_range(0, 1)));
        write_reg(saclp_pkg::CFG_WRITE_ALLOCATE, 4'($urandom_range(0, 1)));
        write_reg(saclp_pkg::CFG_PREFETCH_MODE, 4'($urandom_range(0, 7)));
      end
      @(negedge clk);
      cfg_we <= 1'b0;
      sh = int'(r_off) + ((int'(r_set) > LMS) ? LMS : int'(r_set));
      for (int n = 0; n < 25; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          // small hot region so that sets fill, hit and evict
          a = (32'($urandom_range(0, 11)) << sh) | (32'($urandom_range(0, 3)) << r_off)
              | (32'($urandom) & ((32'd1 << r_off) - 1));
        end else if (pick < 85) begin
          a = prev + (32'd1 << r_off);
        end else begin
          a = $urandom;
        end
        prev = a;
        it.mode = 1'($urandom_range(0, 1));
        it.address = a;
        it.access_bytes = 4'($urandom_range(1, 8));
        drive_item(it, none);
      end
    end

    wait_quiet();
    if (pending_results.size() != 0) begin
      $error("%0d expected result items never arrived", pending_results.size());
      errs++;
    end
    if (errs == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/saclp_pkg.sv
design/saclp_ctrl.sv
design/saclp_dp.sv
design/set_assoc_cache_lru_prefetch_unit.sv
dv/testbench.sv
